/* hdl/key_value_table_assert.svh */
// assertion macros used by the checker file
`ifndef KEY_VALUE_TABLE_ASSERT_SVH
`define KEY_VALUE_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define KVT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define KVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/kvt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package kvt_pkg;

  // parameter defaults
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int KEY_BITS_DEF    = 32;
  localparam int VALUE_BITS_DEF  = 32;

  // fixed field widths
  localparam int MODE_W      = 3;
  localparam int POS_W       = 6;
  localparam int CAP_W       = 7;
  localparam int COUNT_OUT_W = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // request codes
  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT   = 3'd0,
    MODE_UPDATE   = 3'd1,
    MODE_UPSERT   = 3'd2,
    MODE_ERASE    = 3'd3,
    MODE_CONTAINS = 3'd4,
    MODE_GET_KEY  = 3'd5,
    MODE_GET_POS  = 3'd6
  } kvt_mode_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_FETCH,
    ST_RESP
  } kvt_state_t;

endpackage

`default_nettype wire

/* hdl/kvt_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module kvt_store #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 64,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // one read port, registered data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/key_value_table.sv */
// Unsorted key/value table of up to MAX_ENTRIES pairs held in one pair memory
// (key in the low bits, value above it) with a single read and a single write
// port. One request is taken at a time. Key requests search the stored pairs
// from position 0 upward at one entry per cycle through the read port; an
// erase then moves every later pair down one place at one pair per cycle. Get
// by position reads its pair directly, with no search, and fails without a
// read when the position is out of range; a mode with no meaning is answered
// with a failure. The next request is taken as soon as the result sits in the
// output register, even while that result still waits to be taken. The user
// must write capacity_limit only while no request is in flight; the block
// itself does not enforce this. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module key_value_table #(
  parameter int MAX_ENTRIES = kvt_pkg::MAX_ENTRIES_DEF,
  parameter int KEY_BITS    = kvt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS  = kvt_pkg::VALUE_BITS_DEF,
  localparam int IN_W       = KEY_BITS + VALUE_BITS + kvt_pkg::POS_W,
  localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W      = KEY_BITS + VALUE_BITS + kvt_pkg::COUNT_OUT_W,
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // request channel
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [kvt_pkg::MODE_W-1:0]   in_tuser,   // mode
  input  wire logic [IN_TDATA_W-1:0]        in_tdata,   // key_in, value_in, position
  // result channel
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic                              out_tuser,  // ok
  output logic      [OUT_TDATA_W-1:0]       out_tdata,  // key_out, value_out, entry_count
  // capacity register
  input  wire logic                         cfg_wen,
  input  wire logic [kvt_pkg::CAP_W-1:0]    cfg_wdata   // capacity_limit
);

  import kvt_pkg::*;

  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int PAIR_W = KEY_BITS + VALUE_BITS;
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int PCMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  kvt_state_t state_r, state_nxt;

  logic [MODE_W-1:0]     mode_r, mode_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CAP_W-1:0]      cap_r, cap_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic                  pend_r, pend_nxt;
  logic [ADDR_W-1:0]     pend_idx_r, pend_idx_nxt;
  logic                  ok_r, ok_nxt;
  logic [KEY_BITS-1:0]   rkey_r, rkey_nxt;
  logic [VALUE_BITS-1:0] rval_r, rval_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_ok_r, out_ok_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // memory port signals
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [PAIR_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [PAIR_W-1:0] mem_rdata;

  // request fields
  logic [KEY_BITS-1:0]   in_key;
  logic [VALUE_BITS-1:0] in_val;
  logic [POS_W-1:0]      in_pos;
  logic [KEY_BITS-1:0]   q_key;
  logic [VALUE_BITS-1:0] q_val;
  logic                  more;
  logic                  room;
  logic                  hit;

  assign in_key = in_tdata[KEY_BITS-1:0];
  assign in_val = in_tdata[KEY_BITS +: VALUE_BITS];
  assign in_pos = in_tdata[PAIR_W +: POS_W];
  assign q_key  = mem_rdata[KEY_BITS-1:0];
  assign q_val  = mem_rdata[KEY_BITS +: VALUE_BITS];

  // scan still has entries to read
  assign more = idx_r < cnt_r;
  // space left under both the register and the memory size
  assign room = (CMP_W'(cnt_r) < CMP_W'(cap_r)) && (cnt_r < CNT_W'(MAX_ENTRIES));
  // returned key matches the request
  assign hit  = pend_r && (q_key == key_r);

  kvt_store #(
    .DEPTH  (MAX_ENTRIES),
    .WIDTH  (PAIR_W),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      cap_r       <= CAP_RESET;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cap_r       <= cap_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    idx_r      <= idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    ok_r       <= ok_nxt;
    rkey_r     <= rkey_nxt;
    rval_r     <= rval_nxt;
    out_ok_r   <= out_ok_nxt;
    out_data_r <= out_data_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    cap_nxt       = cfg_wen ? cfg_wdata : cap_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    ok_nxt        = ok_r;
    rkey_nxt      = rkey_r;
    rval_nxt      = rval_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_ok_nxt    = out_ok_r;
    out_data_nxt  = out_data_r;
    in_tready     = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = {val_r, key_r};
    mem_re        = 1'b0;
    mem_raddr     = '0;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          mode_nxt = in_tuser;
          key_nxt  = in_key;
          val_nxt  = in_val;
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          ok_nxt   = 1'b0;
          rkey_nxt = '0;
          rval_nxt = '0;
          unique case (in_tuser) inside
            MODE_INSERT, MODE_UPDATE, MODE_UPSERT, MODE_ERASE, MODE_CONTAINS,
            MODE_GET_KEY: begin
              state_nxt = ST_SEARCH;
            end
            MODE_GET_POS: begin
              if (PCMP_W'(in_pos) < PCMP_W'(cnt_r)) begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(in_pos);
                state_nxt = ST_FETCH;
              end else begin
                state_nxt = ST_RESP;
              end
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      ST_SEARCH: begin
        // issue the next read while the previous one is compared
        pend_nxt = more;
        if (more) begin
          mem_re       = 1'b1;
          mem_raddr    = ADDR_W'(idx_r);
          idx_nxt      = idx_r + CNT_W'(1);
          pend_idx_nxt = ADDR_W'(idx_r);
        end
        if (hit) begin
          pend_nxt = 1'b0;
          ok_nxt   = (mode_r != MODE_INSERT);
          unique case (mode_r) inside
            MODE_UPDATE, MODE_UPSERT: begin
              mem_we    = 1'b1;
              mem_waddr = pend_idx_r;
              state_nxt = ST_RESP;
            end
            MODE_GET_KEY: begin
              rval_nxt  = q_val;
              state_nxt = ST_RESP;
            end
            MODE_ERASE: begin
              // compaction starts with the pair after the hit
              idx_nxt   = CNT_W'(pend_idx_r) + CNT_W'(1);
              state_nxt = ST_SHIFT;
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end else if (!pend_r && !more) begin
          // key absent: append for the inserting modes
          if ((mode_r == MODE_INSERT || mode_r == MODE_UPSERT) && room) begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(cnt_r);
            cnt_nxt   = cnt_r + CNT_W'(1);
            ok_nxt    = 1'b1;
          end
          state_nxt = ST_RESP;
        end
      end

      ST_SHIFT: begin
        // read one pair ahead, write it back one place lower
        pend_nxt = more;
        if (more) begin
          mem_re       = 1'b1;
          mem_raddr    = ADDR_W'(idx_r);
          idx_nxt      = idx_r + CNT_W'(1);
          pend_idx_nxt = ADDR_W'(idx_r);
        end
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pend_idx_r - ADDR_W'(1);
          mem_wdata = mem_rdata;
        end else if (!more) begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = ST_RESP;
        end
      end

      ST_FETCH: begin
        ok_nxt    = 1'b1;
        rkey_nxt  = q_key;
        rval_nxt  = q_val;
        state_nxt = ST_RESP;
      end

      ST_RESP: begin
        // load the output register once it is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_data_nxt  = OUT_TDATA_W'({COUNT_OUT_W'(cnt_r), rval_r, rkey_r});
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

/* hdl/kvt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "key_value_table_assert.svh"

module kvt_checker #(
  parameter int MAX_ENTRIES = kvt_pkg::MAX_ENTRIES_DEF,
  parameter int KEY_BITS    = kvt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS  = kvt_pkg::VALUE_BITS_DEF,
  localparam int OUT_W      = KEY_BITS + VALUE_BITS + kvt_pkg::COUNT_OUT_W,
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic                   out_tuser,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  import kvt_pkg::*;

  localparam int CW = (COUNT_OUT_W > 11) ? COUNT_OUT_W : 11;

  logic [COUNT_OUT_W-1:0] count_seen;
  logic                   key_zero;
  logic                   val_zero;

  assign count_seen = out_tdata[KEY_BITS + VALUE_BITS +: COUNT_OUT_W];
  assign key_zero   = (out_tdata[KEY_BITS-1:0] == '0);
  assign val_zero   = (out_tdata[KEY_BITS +: VALUE_BITS] == '0);

  // a result waiting for its taker stays offered
  `KVT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")

  // one request at a time: no second accept right after one
  `KVT_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "request taken while busy")

  // a failed request reads nothing
  `KVT_ASSERT_NOW(a_fail_zero, out_tvalid && !out_tuser, key_zero && val_zero, "failed request returned data")

  // the count never passes the memory size (checked only below 128 entries)
  `KVT_ASSERT_NOW(a_count_max, out_tvalid, CW'(count_seen) <= CW'(MAX_ENTRIES) || MAX_ENTRIES >= 128, "entry count above table size")

endmodule

bind key_value_table kvt_checker #(
  .MAX_ENTRIES (MAX_ENTRIES),
  .KEY_BITS    (KEY_BITS),
  .VALUE_BITS  (VALUE_BITS)
) u_kvt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata)
);

`default_nettype wire
